FILE: rtl/radix_number_formatter_macros.svh
// Assertion macros used by the checker file of the formatter.
`ifndef RADIX_NUMBER_FORMATTER_MACROS_SVH
`define RADIX_NUMBER_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while dis is true.
`define RNF_ASSERT_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("radix_number_formatter: assertion failed");

// Next-cycle implication, disabled while dis is true.
`define RNF_ASSERT_NXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("radix_number_formatter: assertion failed");

`endif

FILE: rtl/rnf_pkg.sv
package rnf_pkg;

    localparam int VALUE_W        = 32;
    localparam int CH_W           = 8;
    localparam int RADIX_W        = 6;
    localparam int PAD_W          = 6;
    localparam int DIGIT_W        = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 6;

    localparam int MAX_DIGITS_DEF = 32;
    localparam int MAX_DIGITS_HI  = 64;
    localparam int IDX_MAX_W      = $clog2(MAX_DIGITS_HI);
    localparam int CNT_MAX_W      = $clog2(MAX_DIGITS_HI + 1);

    localparam int Q_DEPTH        = 2;
    localparam int Q_PTR_W        = $clog2(Q_DEPTH);

    // The divider retires this many quotient bits per clock.
    localparam int DIV_STEPS      = 8;
    localparam int DIV_CYCLES     = VALUE_W / DIV_STEPS;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    localparam int PREFIX_LEN     = 3;
    localparam int PAD_LIMIT_N    = 60;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [PAD_W-1:0]   PAD_LIMIT   = PAD_W'(PAD_LIMIT_N);

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX         = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_WIDTH     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_ENABLE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_JUSTIFY  = CFG_IDX_W'(4);

    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_B = 8'h42;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;

    typedef enum logic {
        F_IDLE,
        F_DIV
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_START,
        B_LEAD,
        B_PREFIX,
        B_ZERO,
        B_DIGIT,
        B_TRAIL
    } t_back_state;

    // One finished conversion waiting for the emitter.
    typedef struct packed {
        logic                 nz;
        logic [CNT_MAX_W-1:0] n;
    } t_desc;

    // Digit write from the converter into the digit store.
    typedef struct packed {
        logic                 en;
        logic [Q_PTR_W-1:0]   slot;
        logic [IDX_MAX_W-1:0] idx;
        logic [DIGIT_W-1:0]   digit;
    } t_dig_wr;

    typedef struct packed {
        logic [PAD_W-1:0] pad_width;
        logic             zero_pad;
        logic             prefix_enable;
        logic             left_justify;
    } t_fmt_cfg;

    // Digit value to its character: 0-9, then uppercase A-Z.
    function automatic logic [CH_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] m;
        m = (d >= DIGIT_W'(36)) ? DIGIT_W'(d - DIGIT_W'(36)) : d;
        if (m < DIGIT_W'(10)) begin
            digit_char = CH_ZERO + CH_W'(m);
        end else begin
            digit_char = CH_UPPER_A + CH_W'(m - DIGIT_W'(10));
        end
    endfunction

endpackage

FILE: rtl/rnf_front.sv
module rnf_front #(
    parameter int MAX_DIGITS = rnf_pkg::MAX_DIGITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [rnf_pkg::VALUE_W-1:0]       i_value,
    input  logic [rnf_pkg::RADIX_W-1:0]       i_radix,
    input  logic                              i_q_full,
    input  logic [rnf_pkg::Q_PTR_W-1:0]       i_q_wr_ptr,
    output logic                              o_push,
    output rnf_pkg::t_desc                    o_desc,
    output rnf_pkg::t_dig_wr                  o_dig_wr
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    rnf_pkg::t_front_state r_state, n_state;
    logic [rnf_pkg::VALUE_W-1:0]   r_q, n_q;
    logic [rnf_pkg::DIGIT_W-1:0]   r_rem, n_rem;
    logic [rnf_pkg::DIV_CNT_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]              r_n, n_n;
    logic                          r_nz, n_nz;

    logic [rnf_pkg::VALUE_W-1:0]   div_q;
    logic [rnf_pkg::DIGIT_W-1:0]   div_rem;
    logic [rnf_pkg::DIGIT_W:0]     div_t;
    logic                          radix_ok;
    logic                          digit_done;
    logic                          conv_done;
    logic [CNT_W-1:0]              n_plus;
    logic                          dig_en;

    // Restoring division, several quotient bits per clock.
    always_comb begin
        div_q   = r_q;
        div_rem = r_rem;
        div_t   = '0;
        for (int k = 0; k < rnf_pkg::DIV_STEPS; k++) begin
            div_t = {div_rem, div_q[rnf_pkg::VALUE_W-1]};
            if (div_t >= {1'b0, i_radix}) begin
                div_rem = rnf_pkg::DIGIT_W'(div_t - {1'b0, i_radix});
                div_q   = {div_q[rnf_pkg::VALUE_W-2:0], 1'b1};
            end else begin
                div_rem = div_t[rnf_pkg::DIGIT_W-1:0];
                div_q   = {div_q[rnf_pkg::VALUE_W-2:0], 1'b0};
            end
        end
    end

    assign radix_ok   = i_radix inside {[rnf_pkg::RADIX_MIN:rnf_pkg::RADIX_MAX]};
    assign digit_done = (r_step == rnf_pkg::DIV_CNT_W'(rnf_pkg::DIV_CYCLES - 1));
    assign n_plus     = CNT_W'(r_n + 1'b1);
    assign conv_done  = digit_done && ((div_q == '0) || (n_plus == CNT_W'(MAX_DIGITS)));

    assign o_desc.nz = r_nz;
    assign o_desc.n  = rnf_pkg::CNT_MAX_W'(n_plus);

    assign o_dig_wr.en    = dig_en;
    assign o_dig_wr.slot  = i_q_wr_ptr;
    assign o_dig_wr.idx   = rnf_pkg::IDX_MAX_W'(r_n[IDX_W-1:0]);
    assign o_dig_wr.digit = div_rem;

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_rem       = r_rem;
        n_step      = r_step;
        n_n         = r_n;
        n_nz        = r_nz;
        o_ready     = 1'b0;
        o_push      = 1'b0;
        dig_en      = 1'b0;
        case (r_state)
            rnf_pkg::F_IDLE: begin
                o_ready = !i_q_full;
                // A value in an unsupported radix is taken and dropped.
                if (i_valid && !i_q_full && radix_ok) begin
                    n_q     = i_value;
                    n_rem   = '0;
                    n_step  = '0;
                    n_n     = '0;
                    n_nz    = (i_value != '0);
                    n_state = rnf_pkg::F_DIV;
                end
            end
            rnf_pkg::F_DIV: begin
                n_q    = div_q;
                n_rem  = div_rem;
                n_step = rnf_pkg::DIV_CNT_W'(r_step + 1'b1);
                if (digit_done) begin
                    dig_en = 1'b1;
                    n_n    = n_plus;
                    n_rem  = '0;
                    n_step = '0;
                    if (conv_done) begin
                        o_push  = 1'b1;
                        n_state = rnf_pkg::F_IDLE;
                    end
                end
            end
            default: begin
                n_state = rnf_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rnf_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_n    <= n_n;
        r_nz   <= n_nz;
    end

endmodule

FILE: rtl/rnf_queue.sv
module rnf_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  rnf_pkg::t_desc              i_desc,
    output logic                        o_full,
    output logic [rnf_pkg::Q_PTR_W-1:0] o_wr_ptr,
    input  logic                        i_pop,
    output logic                        o_empty,
    output rnf_pkg::t_desc              o_head,
    output logic [rnf_pkg::Q_PTR_W-1:0] o_rd_ptr
);

    localparam int FILL_W = $clog2(rnf_pkg::Q_DEPTH + 1);

    rnf_pkg::t_desc              r_desc [rnf_pkg::Q_DEPTH];
    logic [rnf_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [rnf_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0]           r_fill, n_fill;

    assign o_full   = (r_fill == FILL_W'(rnf_pkg::Q_DEPTH));
    assign o_empty  = (r_fill == '0);
    assign o_wr_ptr = r_wr_ptr;
    assign o_rd_ptr = r_rd_ptr;
    assign o_head   = r_desc[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? rnf_pkg::Q_PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? rnf_pkg::Q_PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_fill   = r_fill;
        if (i_push && !i_pop) begin
            n_fill = FILL_W'(r_fill + 1'b1);
        end else if (!i_push && i_pop) begin
            n_fill = FILL_W'(r_fill - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_desc[r_wr_ptr] <= i_desc;
        end
    end

endmodule

FILE: rtl/rnf_back.sv
module rnf_back #(
    parameter int MAX_DIGITS = rnf_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rnf_pkg::t_fmt_cfg           i_cfg,
    input  rnf_pkg::t_dig_wr            i_dig_wr,
    input  logic                        i_q_empty,
    input  rnf_pkg::t_desc              i_head,
    input  logic [rnf_pkg::Q_PTR_W-1:0] i_rd_ptr,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rnf_pkg::CH_W-1:0]    o_ch,
    output logic                        o_last
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int LEN_W = $clog2(MAX_DIGITS + rnf_pkg::PAD_LIMIT_N + rnf_pkg::PREFIX_LEN + 1);
    localparam int PW    = rnf_pkg::PAD_W;

    logic [rnf_pkg::DIGIT_W-1:0] r_digit_mem [rnf_pkg::Q_DEPTH][MAX_DIGITS];
    logic [rnf_pkg::DIGIT_W-1:0] r_rd_data;

    rnf_pkg::t_back_state r_state, n_state;
    logic [PW-1:0]           r_fill, n_fill;
    logic [PW-1:0]           r_zeros, n_zeros;
    logic                    r_pre, n_pre;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [LEN_W-1:0]        r_cnt, n_cnt;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [LEN_W-1:0]        r_left, n_left;
    logic                    r_out_valid, n_out_valid;
    logic [rnf_pkg::CH_W-1:0] r_out_ch, n_out_ch;
    logic                    r_out_last, n_out_last;

    logic [PW-1:0]        pad;
    logic [CNT_W-1:0]     head_n;
    logic                 head_pre;
    logic [PW-1:0]        head_zeros;
    logic [LEN_W-1:0]     head_body;
    logic [PW-1:0]        head_fill;

    rnf_pkg::t_back_state after_prefix, after_lead, after_digit, first_phase, follow;
    logic                 emit;
    logic                 advance;
    logic [rnf_pkg::CH_W-1:0] emit_ch;

    // Digit store, one bank per queue slot.
    always_ff @(posedge i_clk) begin
        if (i_dig_wr.en) begin
            r_digit_mem[i_dig_wr.slot][i_dig_wr.idx[IDX_W-1:0]] <= i_dig_wr.digit;
        end
        r_rd_data <= r_digit_mem[i_rd_ptr][n_idx];
    end

    // Field layout of the transaction at the head of the queue.
    always_comb begin
        pad      = (i_cfg.pad_width > rnf_pkg::PAD_LIMIT) ? rnf_pkg::PAD_LIMIT : i_cfg.pad_width;
        head_n   = i_head.n[CNT_W-1:0];
        head_pre = i_cfg.prefix_enable && i_head.nz;
        if ((pad != '0) && i_cfg.zero_pad && (LEN_W'(head_n) < LEN_W'(pad))) begin
            head_zeros = PW'(LEN_W'(pad) - LEN_W'(head_n));
        end else begin
            head_zeros = '0;
        end
        head_body = LEN_W'(LEN_W'(head_n) + LEN_W'(head_zeros)
                  + (head_pre ? LEN_W'(rnf_pkg::PREFIX_LEN) : LEN_W'(0)));
        if ((pad != '0) && !i_cfg.zero_pad && (head_body < LEN_W'(pad))) begin
            head_fill = PW'(LEN_W'(pad) - head_body);
        end else begin
            head_fill = '0;
        end
    end

    assign advance      = !r_out_valid || i_ready;
    assign after_prefix = (r_zeros != '0) ? rnf_pkg::B_ZERO : rnf_pkg::B_DIGIT;
    assign after_lead   = r_pre ? rnf_pkg::B_PREFIX : after_prefix;
    assign after_digit  = (i_cfg.left_justify && (r_fill != '0)) ? rnf_pkg::B_TRAIL
                                                                 : rnf_pkg::B_IDLE;
    assign first_phase  = (!i_cfg.left_justify && (r_fill != '0)) ? rnf_pkg::B_LEAD
                                                                  : after_lead;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_zeros     = r_zeros;
        n_pre       = r_pre;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out_ch    = r_out_ch;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        emit        = 1'b0;
        emit_ch     = rnf_pkg::CH_SPACE;
        follow      = rnf_pkg::B_IDLE;

        case (r_state)
            rnf_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = rnf_pkg::B_LOAD;
                end
            end
            rnf_pkg::B_LOAD: begin
                n_fill  = head_fill;
                n_zeros = head_zeros;
                n_pre   = head_pre;
                n_n     = head_n;
                n_left  = LEN_W'(head_body + LEN_W'(head_fill));
                n_state = rnf_pkg::B_START;
            end
            rnf_pkg::B_START: begin
                n_state = first_phase;
            end
            rnf_pkg::B_LEAD: begin
                emit    = 1'b1;
                emit_ch = rnf_pkg::CH_SPACE;
                follow  = after_lead;
            end
            rnf_pkg::B_PREFIX: begin
                emit    = 1'b1;
                emit_ch = (r_cnt == LEN_W'(2)) ? rnf_pkg::CH_UPPER_B : rnf_pkg::CH_HASH;
                follow  = after_prefix;
            end
            rnf_pkg::B_ZERO: begin
                emit    = 1'b1;
                emit_ch = rnf_pkg::CH_ZERO;
                follow  = rnf_pkg::B_DIGIT;
            end
            rnf_pkg::B_DIGIT: begin
                emit    = 1'b1;
                emit_ch = rnf_pkg::digit_char(r_rd_data);
                follow  = after_digit;
            end
            rnf_pkg::B_TRAIL: begin
                emit    = 1'b1;
                emit_ch = rnf_pkg::CH_SPACE;
                follow  = rnf_pkg::B_IDLE;
            end
            default: begin
                n_state = rnf_pkg::B_IDLE;
            end
        endcase

        if (emit && advance) begin
            n_out_valid = 1'b1;
            n_out_ch    = emit_ch;
            n_out_last  = (r_left == LEN_W'(1));
            n_left      = LEN_W'(r_left - 1'b1);
            n_cnt       = LEN_W'(r_cnt - 1'b1);
            if ((r_state == rnf_pkg::B_DIGIT) && (r_cnt != LEN_W'(1))) begin
                n_idx = IDX_W'(r_idx - 1'b1);
            end
            if (r_cnt == LEN_W'(1)) begin
                n_state = follow;
                o_pop   = (follow == rnf_pkg::B_IDLE);
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end

        // Entering a phase loads its length; digits are read from the top down.
        if (n_state != r_state) begin
            case (n_state)
                rnf_pkg::B_LEAD, rnf_pkg::B_TRAIL: begin
                    n_cnt = LEN_W'(r_fill);
                end
                rnf_pkg::B_PREFIX: begin
                    n_cnt = LEN_W'(rnf_pkg::PREFIX_LEN);
                end
                rnf_pkg::B_ZERO: begin
                    n_cnt = LEN_W'(r_zeros);
                end
                rnf_pkg::B_DIGIT: begin
                    n_cnt = LEN_W'(r_n);
                    n_idx = IDX_W'(r_n - 1'b1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rnf_pkg::B_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill     <= n_fill;
        r_zeros    <= n_zeros;
        r_pre      <= n_pre;
        r_n        <= n_n;
        r_cnt      <= n_cnt;
        r_left     <= n_left;
        r_out_ch   <= n_out_ch;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_ch    = r_out_ch;
    assign o_last  = r_out_last;

endmodule

FILE: rtl/radix_number_formatter.sv
// Radix number formatter: turns 32-bit unsigned values into ASCII text.
// Input channel (i_valid / o_ready / i_value) takes one value per transaction.
// Output channel (o_valid / i_ready / o_ch / o_last) returns one character per
// transaction, most significant digit first, with o_last on the final one.
// The configuration port (i_cfg_we / i_cfg_idx / i_cfg_data) writes radix,
// pad width, zero padding, prefix and justification; write it only while idle.
// A value taken while the radix is outside 2 to 36 produces no characters.
// The converter divides by the radix eight quotient bits per clock and takes
// no new value until the last digit of the current one has been written.
// The emitter sends one character per cycle while the receiver is ready, and
// passes through its idle, load and start states before each value; the
// sustained rate is set by the slower of the two halves.
// A two-entry queue of finished conversions, each with its own digit bank,
// lets the converter work on the next value while the emitter still sends.
// A registered output stage holds a character while the receiver stalls; the
// emitter and then the converter stop when their downstream fills.
// Reset is synchronous: it empties the queue, drops any pending character and
// restores radix 10 with all formatting options off.
module radix_number_formatter #(
    parameter int MAX_DIGITS = rnf_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rnf_pkg::VALUE_W-1:0]     i_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [rnf_pkg::CH_W-1:0]        o_ch,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [rnf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rnf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [rnf_pkg::RADIX_W-1:0] r_radix;
    logic [rnf_pkg::PAD_W-1:0]   r_pad_width;
    logic                        r_zero_pad;
    logic                        r_prefix_enable;
    logic                        r_left_justify;

    rnf_pkg::t_fmt_cfg           fmt_cfg;
    rnf_pkg::t_desc              push_desc;
    rnf_pkg::t_desc              head_desc;
    rnf_pkg::t_dig_wr            dig_wr;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    logic [rnf_pkg::Q_PTR_W-1:0] q_wr_ptr;
    logic [rnf_pkg::Q_PTR_W-1:0] q_rd_ptr;

    // Unknown register indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix         <= rnf_pkg::RADIX_RESET;
            r_pad_width     <= '0;
            r_zero_pad      <= 1'b0;
            r_prefix_enable <= 1'b0;
            r_left_justify  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rnf_pkg::CFG_RADIX:         r_radix <= i_cfg_data[rnf_pkg::RADIX_W-1:0];
                rnf_pkg::CFG_PAD_WIDTH:     r_pad_width <= i_cfg_data[rnf_pkg::PAD_W-1:0];
                rnf_pkg::CFG_ZERO_PAD:      r_zero_pad <= i_cfg_data[0];
                rnf_pkg::CFG_PREFIX_ENABLE: r_prefix_enable <= i_cfg_data[0];
                rnf_pkg::CFG_LEFT_JUSTIFY:  r_left_justify <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign fmt_cfg.pad_width     = r_pad_width;
    assign fmt_cfg.zero_pad      = r_zero_pad;
    assign fmt_cfg.prefix_enable = r_prefix_enable;
    assign fmt_cfg.left_justify  = r_left_justify;

    // Front: takes values and extracts digits, least significant first.
    rnf_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .i_radix    (r_radix),
        .i_q_full   (q_full),
        .i_q_wr_ptr (q_wr_ptr),
        .o_push     (q_push),
        .o_desc     (push_desc),
        .o_dig_wr   (dig_wr)
    );

    // Queue of finished conversions between the two halves.
    rnf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_desc   (push_desc),
        .o_full   (q_full),
        .o_wr_ptr (q_wr_ptr),
        .i_pop    (q_pop),
        .o_empty  (q_empty),
        .o_head   (head_desc),
        .o_rd_ptr (q_rd_ptr)
    );

    // Back: lays out padding, prefix and digits and sends the characters.
    rnf_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (fmt_cfg),
        .i_dig_wr  (dig_wr),
        .i_q_empty (q_empty),
        .i_head    (head_desc),
        .i_rd_ptr  (q_rd_ptr),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_ch      (o_ch),
        .o_last    (o_last)
    );

endmodule

FILE: rtl/rnf_checker.sv
`include "radix_number_formatter_macros.svh"

module rnf_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [rnf_pkg::CH_W-1:0] o_ch,
    input logic                     o_last
);

    // A stalled character stays put.
    `RNF_ASSERT_NXT(a_out_hold, i_clk, !i_rst_n, o_valid && !i_ready, o_valid && $stable(o_ch) && $stable(o_last))

    // Reset leaves nothing pending and the input side open.
    `RNF_ASSERT_NXT(a_reset_clean, i_clk, 1'b0, !i_rst_n, !o_valid && o_ready)

    // Only spaces, the prefix marks, digits and uppercase letters are sent.
    `RNF_ASSERT_IMP(a_char_set, i_clk, !i_rst_n, o_valid, (o_ch == rnf_pkg::CH_SPACE) || (o_ch == rnf_pkg::CH_HASH) || ((o_ch >= rnf_pkg::CH_ZERO) && (o_ch <= rnf_pkg::CH_NINE)) || ((o_ch >= rnf_pkg::CH_UPPER_A) && (o_ch <= rnf_pkg::CH_UPPER_Z)))

    // The prefix is always followed by digits, so a hash never ends a value.
    `RNF_ASSERT_IMP(a_hash_not_last, i_clk, !i_rst_n, o_valid && (o_ch == rnf_pkg::CH_HASH), !o_last)

endmodule

bind radix_number_formatter rnf_checker u_rnf_checker (.*);

FILE: dv/formatter_checker.sv
`timescale 1ns / 1ps

// Watches the value and character channels and the register port of the
// formatter, predicts the characters of every accepted value and compares
// them in order with what the block returns.
module formatter_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [rnf_pkg::VALUE_W-1:0]     i_value,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [rnf_pkg::CH_W-1:0]        i_ch,
    input  logic                            i_last,
    input  logic                            i_cfg_we,
    input  logic [rnf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rnf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_pending,
    output int                              o_mismatches
);
    import rnf_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_char_beat;

    t_char_beat expected_chars[$];
    int         mismatch_count = 0;
    int         pending_count = 0;

    logic [RADIX_W-1:0] radix = RADIX_RESET;
    logic [PAD_W-1:0]   pad_width = '0;
    logic               zero_pad = 1'b0;
    logic               prefix_enable = 1'b0;
    logic               left_justify = 1'b0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatch_count;

    // Queues the characters that one value turns into under the current settings.
    task automatic format_value(input logic [VALUE_W-1:0] value);
        logic [DIGIT_W-1:0] digits [MAX_DIGITS_DEF];
        logic [CH_W-1:0]    text [$];
        logic [VALUE_W-1:0] rest;
        int                 n;
        int                 pad;
        int                 body;
        int                 fill;
        bit                 with_prefix;
        if (radix < RADIX_MIN || radix > RADIX_MAX) return;
        pad = (pad_width > PAD_LIMIT) ? PAD_LIMIT_N : int'(pad_width);
        // Digits come out least significant first; zero gives a single digit.
        rest = value;
        n = 0;
        do begin
            digits[n] = DIGIT_W'(rest % VALUE_W'(radix));
            rest = rest / VALUE_W'(radix);
            n++;
        end while (rest != 0 && n < MAX_DIGITS_DEF);
        with_prefix = prefix_enable && (value != 0);
        body = (pad != 0 && zero_pad && n < pad) ? pad : n;
        if (with_prefix) body += PREFIX_LEN;
        fill = (pad != 0 && !zero_pad && body < pad) ? pad - body : 0;
        if (!left_justify) repeat (fill) text.push_back(CH_SPACE);
        if (with_prefix) begin
            text.push_back(CH_HASH);
            text.push_back(CH_UPPER_B);
            text.push_back(CH_HASH);
        end
        if (pad != 0 && zero_pad) begin
            for (int i = n; i < pad; i++) text.push_back(CH_ZERO);
        end
        for (int i = n - 1; i >= 0; i--) begin
            text.push_back(digits[i] < 10 ? CH_ZERO + CH_W'(digits[i])
                                          : CH_UPPER_A + CH_W'(digits[i] - 10));
        end
        if (left_justify) repeat (fill) text.push_back(CH_SPACE);
        while (text.size() > PAD_LIMIT_N + PREFIX_LEN) void'(text.pop_back());
        foreach (text[i]) begin
            expected_chars.push_back('{ch: text[i], last: (i == text.size() - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        t_char_beat want;
        if (!i_rst_n) begin
            radix = RADIX_RESET;
            pad_width = '0;
            zero_pad = 1'b0;
            prefix_enable = 1'b0;
            left_justify = 1'b0;
            expected_chars.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIX:         radix = i_cfg_data[RADIX_W-1:0];
                    CFG_PAD_WIDTH:     pad_width = i_cfg_data[PAD_W-1:0];
                    CFG_ZERO_PAD:      zero_pad = i_cfg_data[0];
                    CFG_PREFIX_ENABLE: prefix_enable = i_cfg_data[0];
                    CFG_LEFT_JUSTIFY:  left_justify = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) format_value(i_value);
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("ch: expected nothing, actual %h (last %b)", i_ch, i_last);
                    mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_ch !== want.ch) begin
                        $error("ch: expected %h, actual %h", want.ch, i_ch);
                        mismatch_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, i_last);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_count = expected_chars.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

// Top of the formatter testbench. It makes the clock and reset, drives
// values and register writes, and paces the character receiver. All the
// prediction and comparison happens in the checker instantiated beside the
// block; this module only reads its pending and mismatch counts.
module testbench;
    import rnf_pkg::*;

    localparam int RESET_CYCLES     = 7;
    // Converted values in the random phases; the directed pass and the
    // values sent under an invalid radix come on top of these.
    localparam int ITEM_TARGET      = 115;
    // The converter works through a value digit by digit and the queue holds
    // two finished values; this wait covers any value that is still in flight
    // without producing characters.
    localparam int SETTLE_CYCLES    = 300;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_MOSTLY
    } t_ready_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [VALUE_W-1:0]    i_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [CH_W-1:0]       o_ch;
    logic                  o_last;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_RADIX;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int                    pending_chars;
    int                    mismatches;

    // The radix the block currently holds, so that values sent under an
    // invalid radix are not counted as real work.
    logic [RADIX_W-1:0]    radix_now = RADIX_RESET;
    int                    burst_left = 0;

    // Handshake between the stimulus and the receiver for the long hold-off.
    bit                    hold_off_request = 1'b0;
    bit                    hold_off_active = 1'b0;
    bit                    hold_off_done = 1'b0;

    always #4 i_clk = ~i_clk;

    radix_number_formatter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_ch       (o_ch),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    formatter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_value      (i_value),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_ch         (o_ch),
        .i_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending_chars),
        .o_mismatches (mismatches)
    );

    // Drops valid for the given number of cycles; the value bus carries
    // junk meanwhile, which the block must ignore.
    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_value = $urandom;
        end
    endtask

    // Offers one value and returns once the transaction has happened.
    // Values go out in bursts; between bursts the sender idles for a
    // random gap, and sometimes for none at all.
    task automatic offer_value(input logic [VALUE_W-1:0] value);
        if (burst_left == 0) begin
            pause_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12));
            burst_left = $urandom_range(1, 10);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_value = value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
    endtask

    // Waits until every predicted character has arrived, then lets the
    // block run on long enough to finish any value that yields no output.
    task automatic settle();
        pause_sender(1);
        while (pending_chars != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_RADIX) radix_now = data[RADIX_W-1:0];
    endtask

    // Character receiver. It cycles through segments of random length, each
    // with its own pattern of ready, and once on request holds ready low for
    // a long stretch so that the block backs up all the way to its input.
    initial begin
        t_ready_mode mode;
        int          seg_len;
        wait (i_rst_n);
        forever begin
            if (hold_off_request && !hold_off_done) begin
                hold_off_active = 1'b1;
                repeat (LONG_HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_ready = 1'b0;
                end
                hold_off_active = 1'b0;
                hold_off_done = 1'b1;
            end else begin
                mode = t_ready_mode'($urandom_range(3));
                seg_len = $urandom_range(1, 40);
                repeat (seg_len) begin
                    @(negedge i_clk);
                    case (mode)
                        READY_ALWAYS: i_ready = 1'b1;
                        READY_HALF:   i_ready = 1'($urandom_range(1));
                        READY_SPARSE: i_ready = ($urandom_range(3) == 0);
                        default:      i_ready = ($urandom_range(3) != 0);
                    endcase
                end
            end
        end
    end

    // Stimulus: a directed pass over the corners, then random phases, each
    // with fresh settings written while the block is idle.
    initial begin
        int                 bad_radix [4] = '{0, 1, 37, 63};
        int                 items_done;
        int                 phase;
        int                 phase_items;
        int                 pick;
        logic [VALUE_W-1:0] value;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Settings after reset: decimal, no padding, no prefix.
        offer_value(32'd0);
        offer_value(32'd1);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'd12345);
        settle();

        // Highest radix, where the letters run up to Z.
        write_reg(CFG_RADIX, 6'd36);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'd35);
        offer_value(32'd36);
        settle();

        // Lowest radix: the all-ones value gives the full 32 digits.
        write_reg(CFG_RADIX, 6'd2);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'h8000_0000);
        offer_value(32'd0);
        settle();

        // Zero padding to an oversized width, which is clipped to 60, with
        // the prefix added after padding for 63 characters in all. Zero
        // itself never takes the prefix.
        write_reg(CFG_RADIX, 6'd16);
        write_reg(CFG_PAD_WIDTH, 6'd63);
        write_reg(CFG_ZERO_PAD, 6'd1);
        write_reg(CFG_PREFIX_ENABLE, 6'd1);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'd0);
        settle();

        // Space padding on the right, then on the left; the prefix counts
        // toward the field width.
        write_reg(CFG_RADIX, 6'd8);
        write_reg(CFG_PAD_WIDTH, 6'd20);
        write_reg(CFG_ZERO_PAD, 6'd0);
        write_reg(CFG_LEFT_JUSTIFY, 6'd1);
        offer_value(32'd1234);
        offer_value(32'd0);
        settle();
        write_reg(CFG_LEFT_JUSTIFY, 6'd0);
        offer_value(32'hDEAD_BEEF);
        settle();

        // Writes to the unused register indexes must change nothing.
        for (int idx = int'(CFG_LEFT_JUSTIFY) + 1; idx < 2 ** CFG_IDX_W; idx++) begin
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        end
        offer_value(32'd77);
        settle();

        // A radix outside 2 to 36 swallows the value without a character.
        foreach (bad_radix[i]) begin
            write_reg(CFG_RADIX, CFG_DATA_W'(bad_radix[i]));
            offer_value($urandom);
            settle();
        end

        items_done = 0;
        phase = 0;
        while (items_done < ITEM_TARGET) begin
            // Radix: mostly in range, with the two extremes and the odd
            // invalid one. The phase with the long hold-off always converts.
            pick = $urandom_range(7);
            if (pick == 0 && phase != 1) begin
                pick = $urandom_range(28);
                write_reg(CFG_RADIX, CFG_DATA_W'((pick < 2) ? pick : pick + 35));
            end else if (pick == 1) begin
                write_reg(CFG_RADIX, RADIX_MIN);
            end else if (pick == 2) begin
                write_reg(CFG_RADIX, RADIX_MAX);
            end else begin
                write_reg(CFG_RADIX, CFG_DATA_W'($urandom_range(2, 36)));
            end
            case ($urandom_range(3))
                0:       write_reg(CFG_PAD_WIDTH, 6'd0);
                1:       write_reg(CFG_PAD_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
                2:       write_reg(CFG_PAD_WIDTH, CFG_DATA_W'($urandom_range(63)));
                default: write_reg(CFG_PAD_WIDTH, CFG_DATA_W'($urandom_range(58, 63)));
            endcase
            write_reg(CFG_ZERO_PAD, CFG_DATA_W'($urandom_range(1)));
            write_reg(CFG_PREFIX_ENABLE, CFG_DATA_W'($urandom_range(1)));
            write_reg(CFG_LEFT_JUSTIFY, CFG_DATA_W'($urandom_range(1)));

            phase_items = $urandom_range(4, 16);
            if (phase == 1) begin
                // Keep offering while the receiver holds off, so that the
                // output stage and the conversion queue fill and the input
                // stalls.
                hold_off_request = 1'b1;
                wait (hold_off_active);
                phase_items = 16;
            end

            repeat (phase_items) begin
                case ($urandom_range(5))
                    0: value = $urandom_range(40);
                    1: value = 32'hFFFF_FFFF >> $urandom_range(31);
                    2: value = 32'd1 << $urandom_range(31);
                    3: begin
                        // Around a power of the radix, where the digit count
                        // steps up.
                        value = 32'd1;
                        if (radix_now > 1) begin
                            repeat ($urandom_range(1, 31)) begin
                                if (value <= 32'hFFFF_FFFF / radix_now) value *= radix_now;
                            end
                        end
                        value = value - $urandom_range(1);
                    end
                    default: value = $urandom;
                endcase
                offer_value(value);
                if (radix_now >= RADIX_MIN && radix_now <= RADIX_MAX) items_done++;
            end
            settle();
            phase++;
        end

        if (mismatches == 0 && pending_chars == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit, well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rnf_pkg.sv
rtl/rnf_front.sv
rtl/rnf_queue.sv
rtl/rnf_back.sv
rtl/radix_number_formatter.sv
rtl/rnf_checker.sv
dv/formatter_checker.sv
dv/testbench.sv
